/* rtl/core/urr_pkg.sv */
package urr_pkg;

    localparam int unsigned MM_W       = 14;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 56;

    // Low trigger ticks ahead of the high trigger pulse
    localparam logic [4:0] PRE_TRIGGER_TICKS = 5'd2;

    localparam logic [13:0] MAX14    = 14'h3FFF;
    localparam logic [15:0] MAX16    = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SLOT_TICKS     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ECHO_TIMEOUT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ECHO_WIDTH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_TICKS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE          = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_SLOT_TICKS     = 16'd25000;
    localparam logic [13:0] RST_ECHO_TIMEOUT   = 14'd12000;
    localparam logic [13:0] RST_MAX_ECHO_WIDTH = 14'd11661;
    localparam logic [4:0]  RST_TRIGGER_TICKS  = 5'd10;
    localparam logic [15:0] RST_SCALE          = 16'd11239;

    // Sequencer phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PRE   = 3'd1;
    localparam logic [2:0] PH_TRIG  = 3'd2;
    localparam logic [2:0] PH_WLOW  = 3'd3;
    localparam logic [2:0] PH_WHIGH = 3'd4;
    localparam logic [2:0] PH_MEAS  = 3'd5;

    // Sensor selection codes
    localparam logic [1:0] SENSOR_LEFT   = 2'd0;
    localparam logic [1:0] SENSOR_MIDDLE = 2'd1;
    localparam logic [1:0] SENSOR_RIGHT  = 2'd2;
    localparam logic [1:0] SENSOR_NONE3  = 2'd3;

    typedef struct packed {
        logic [15:0] slot_ticks;
        logic [13:0] echo_timeout;
        logic [13:0] max_echo_width;
        logic [4:0]  trigger_ticks;
        logic [15:0] scale;
    } urr_cfg_t;

    // First member sits in the highest bits; trigger_lines ends up at bit 0
    typedef struct packed {
        logic              busy_res;
        logic [1:0]        updated_sensor;
        logic              right_valid;
        logic [MM_W-1:0]   right_mm;
        logic              middle_valid;
        logic [MM_W-1:0]   middle_mm;
        logic              left_valid;
        logic [MM_W-1:0]   left_mm;
        logic [2:0]        trigger_lines;
    } urr_result_t;

endpackage

/* rtl/core/urr_seq.sv */
module urr_seq #(
    parameter logic [4:0] PRE_TRIGGER_TICKS = urr_pkg::PRE_TRIGGER_TICKS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic [2:0]         echo_lines,
    input  urr_pkg::urr_cfg_t  cfg,
    output urr_pkg::urr_result_t result
);
    import urr_pkg::*;

    logic [15:0]     slot_elapsed_reg, slot_elapsed_next, slot_inc;
    logic [1:0]      next_sensor_reg, next_sensor_next;
    logic [2:0]      phase_reg, phase_next;
    logic [4:0]      phase_count_reg, phase_count_next;
    logic [13:0]     wait_count_reg, wait_count_next, wait_inc;
    logic [13:0]     echo_width_reg, echo_width_next;
    logic [MM_W-1:0] dist_reg [3];
    logic [MM_W-1:0] dist_next [3];
    logic [2:0]      valid_reg, valid_next;

    logic [1:0]      cur;
    logic            ch;
    logic            fin;
    logic            fin_meas;
    logic [13:0]     fin_w;
    logic [29:0]     prod;
    logic            ok;
    logic [1:0]      updated;

    assign cur      = (next_sensor_reg == SENSOR_NONE3) ? SENSOR_RIGHT : next_sensor_reg;
    assign ch       = echo_lines[cur];
    assign slot_inc = (slot_elapsed_reg == MAX16) ? slot_elapsed_reg : slot_elapsed_reg + 16'd1;
    assign wait_inc = (wait_count_reg == MAX14) ? wait_count_reg : wait_count_reg + 14'd1;

    // Distance of the finishing reading
    assign prod = 30'(fin_w) * 30'(cfg.scale);
    assign ok   = (fin_w != 14'd0) && (fin_w <= cfg.max_echo_width);

    always_comb
    begin
        slot_elapsed_next = slot_inc;
        next_sensor_next  = next_sensor_reg;
        phase_next        = phase_reg;
        phase_count_next  = phase_count_reg;
        wait_count_next   = wait_count_reg;
        echo_width_next   = echo_width_reg;
        fin               = 1'b0;
        fin_meas          = 1'b0;
        fin_w             = 14'd0;
        updated           = 2'd0;
        unique case (phase_reg)
            PH_PRE:
            begin
                if (phase_count_reg >= PRE_TRIGGER_TICKS)
                begin
                    phase_next       = PH_TRIG;
                    phase_count_next = 5'd1;
                end
                else
                begin
                    phase_count_next = phase_count_reg + 5'd1;
                end
            end
            PH_TRIG:
            begin
                if (phase_count_reg >= cfg.trigger_ticks)
                begin
                    phase_next       = PH_WLOW;
                    phase_count_next = 5'd0;
                    wait_count_next  = 14'd0;
                    echo_width_next  = 14'd0;
                end
                else
                begin
                    phase_count_next = phase_count_reg + 5'd1;
                end
            end
            PH_WLOW, PH_WHIGH, PH_MEAS:
            begin
                if (phase_reg == PH_WLOW)
                begin
                    if (!ch)
                    begin
                        phase_next = PH_WHIGH;
                    end
                end
                else if (phase_reg == PH_WHIGH)
                begin
                    if (ch)
                    begin
                        phase_next      = PH_MEAS;
                        echo_width_next = 14'd1;
                    end
                end
                else if (ch)
                begin
                    echo_width_next = (echo_width_reg == MAX14) ? echo_width_reg
                                                                : echo_width_reg + 14'd1;
                end
                else
                begin
                    fin_meas = 1'b1;
                end

                if (fin_meas)
                begin
                    fin   = 1'b1;
                    fin_w = echo_width_reg;
                end
                else
                begin
                    wait_count_next = wait_inc;
                    // Timeout reports width zero
                    if (wait_inc >= cfg.echo_timeout)
                    begin
                        fin   = 1'b1;
                        fin_w = 14'd0;
                    end
                end

                if (fin)
                begin
                    phase_next       = PH_IDLE;
                    phase_count_next = 5'd0;
                    next_sensor_next = (cur == SENSOR_RIGHT) ? SENSOR_LEFT : cur + 2'd1;
                    updated          = cur + 2'd1;
                end
            end
            default:
            begin
                // Idle and unused codes: start when the slot has run out
                phase_next = PH_IDLE;
                if (slot_inc >= cfg.slot_ticks)
                begin
                    slot_elapsed_next = 16'd0;
                    phase_next        = PH_PRE;
                    phase_count_next  = 5'd1;
                end
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < 3; i++)
        begin
            dist_next[i] = dist_reg[i];
            if (fin && (cur == 2'(i)))
            begin
                dist_next[i]  = ok ? prod[29:16] : '0;
                valid_next[i] = ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_elapsed_reg <= '0;
            next_sensor_reg  <= SENSOR_LEFT;
            phase_reg        <= PH_IDLE;
            phase_count_reg  <= '0;
            wait_count_reg   <= '0;
            echo_width_reg   <= '0;
            valid_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                dist_reg[i] <= '0;
            end
        end
        else if (tick)
        begin
            slot_elapsed_reg <= slot_elapsed_next;
            next_sensor_reg  <= next_sensor_next;
            phase_reg        <= phase_next;
            phase_count_reg  <= phase_count_next;
            wait_count_reg   <= wait_count_next;
            echo_width_reg   <= echo_width_next;
            valid_reg        <= valid_next;
            for (int i = 0; i < 3; i++)
            begin
                dist_reg[i] <= dist_next[i];
            end
        end
    end

    always_comb
    begin
        result.trigger_lines  = (phase_next == PH_TRIG) ? (3'b001 << cur) : 3'b000;
        result.left_mm        = dist_next[0];
        result.left_valid     = valid_next[0];
        result.middle_mm      = dist_next[1];
        result.middle_valid   = valid_next[1];
        result.right_mm       = dist_next[2];
        result.right_valid    = valid_next[2];
        result.updated_sensor = updated;
        result.busy_res       = (phase_next != PH_IDLE);
    end

endmodule

/* rtl/core/urr_obuf.sv */
module urr_obuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  urr_pkg::urr_result_t din,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output urr_pkg::urr_result_t dout
);
    import urr_pkg::*;

    urr_result_t main_reg, skid_reg;
    logic        main_valid_reg, skid_valid_reg;
    logic        pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign dout      = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (pop)
            begin
                main_valid_reg <= skid_valid_reg || push;
                skid_valid_reg <= skid_valid_reg && push;
            end
            else if (push)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= main_valid_reg;
            end
            else
            begin
                main_valid_reg <= main_valid_reg;
                skid_valid_reg <= skid_valid_reg;
            end
        end
    end

    // Payload: refill the head from the skid stage first
    always_ff @(posedge clk)
    begin
        priority if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                skid_reg <= din;
            end
            else
            begin
                main_reg <= din;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= din;
            end
            else
            begin
                main_reg <= din;
            end
        end
        else
        begin
            main_reg <= main_reg;
            skid_reg <= skid_reg;
        end
    end

endmodule

/* rtl/core/three_channel_ultrasonic_ranger.sv */
// A tick's result enters the output buffer at the edge that accepts the tick.
// Throughput: one tick per clock while s_axis_tready is high; the
// sequencer and counters advance once per transfer. A two-entry output
// buffer keeps taking ticks while one result waits downstream;
// s_axis_tready drops only when both entries are full.
// Reset (rst_n low, asynchronous) clears the sequencer to idle, left sensor next,
// all distances and valid flags to zero, and loads the default register values.
module three_channel_ultrasonic_ranger #(
    parameter logic [4:0] PRE_TRIGGER_TICKS = urr_pkg::PRE_TRIGGER_TICKS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input tick: tdata[2:0] echo_lines, upper bits zero
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [urr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Result: tdata from bit 0 up: trigger_lines[3], left_mm[14], left_valid,
    // middle_mm[14], middle_valid, right_mm[14], right_valid, updated_sensor[2],
    // busy_res, then zero fill
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [urr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Register writes
    input  logic                               cfg_we,
    input  logic [urr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [urr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import urr_pkg::*;

    urr_cfg_t    cfg_reg;
    urr_result_t seq_result;
    urr_result_t buf_result;
    logic        tick;
    logic        can_push;

    // Register file; writes outside the map drop silently
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_ticks     <= RST_SLOT_TICKS;
            cfg_reg.echo_timeout   <= RST_ECHO_TIMEOUT;
            cfg_reg.max_echo_width <= RST_MAX_ECHO_WIDTH;
            cfg_reg.trigger_ticks  <= RST_TRIGGER_TICKS;
            cfg_reg.scale          <= RST_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SLOT_TICKS:     cfg_reg.slot_ticks     <= cfg_data;
                REG_ECHO_TIMEOUT:   cfg_reg.echo_timeout   <= cfg_data[13:0];
                REG_MAX_ECHO_WIDTH: cfg_reg.max_echo_width <= cfg_data[13:0];
                REG_TRIGGER_TICKS:  cfg_reg.trigger_ticks  <= cfg_data[4:0];
                REG_SCALE:          cfg_reg.scale          <= cfg_data;
                default:            ;
            endcase
        end
    end

    // One input transfer advances the ranger by one tick
    assign s_axis_tready = can_push;
    assign tick          = s_axis_tvalid && can_push;

    urr_seq #(
        .PRE_TRIGGER_TICKS (PRE_TRIGGER_TICKS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .echo_lines (s_axis_tdata[2:0]),
        .cfg        (cfg_reg),
        .result     (seq_result)
    );

    urr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tick),
        .din       (seq_result),
        .can_push  (can_push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .dout      (buf_result)
    );

    assign m_axis_tdata = {(OUT_DATA_W - $bits(urr_result_t))'(0), buf_result};

endmodule

/* rtl/core/urr_checker.sv */
module urr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // At most one trigger line high
    a_trig_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
        else $error("more than one trigger line driven");

    // Trigger only while a ranging runs
    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != 3'd0) |-> m_axis_tdata[50])
        else $error("trigger driven while idle");

    // A finished reading leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[49:48] != 2'd0) |-> !m_axis_tdata[50])
        else $error("update reported while busy");

    // An invalid reading stores zero distance
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17] || (m_axis_tdata[16:3] == 14'd0))
                       && (m_axis_tdata[32] || (m_axis_tdata[31:18] == 14'd0))
                       && (m_axis_tdata[47] || (m_axis_tdata[46:33] == 14'd0)))
        else $error("nonzero distance with valid flag clear");

endmodule

bind three_channel_ultrasonic_ranger urr_checker u_urr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/ranger_checker.sv */
`timescale 1ns / 1ps

module ranger_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [urr_pkg::IN_DATA_W-1:0]      s_data,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [urr_pkg::OUT_DATA_W-1:0]     m_data,
    input  logic                               cfg_we,
    input  logic [urr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [urr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 readings_due
);
    import urr_pkg::*;

    // Register copy
    logic [15:0] slot_ticks;
    logic [13:0] echo_timeout;
    logic [13:0] max_echo_width;
    logic [4:0]  trigger_ticks;
    logic [15:0] scale;

    // Sequencer copy
    logic [15:0] slot_elapsed;
    logic [1:0]  next_sensor;
    logic [2:0]  phase;
    logic [4:0]  phase_count;
    logic [13:0] wait_count;
    logic [13:0] echo_width;
    logic [13:0] distance_mm [3];
    logic        reading_ok [3];

    urr_result_t expected_readings [$];
    int          fail_tally = 0;

    function automatic logic [1:0] active_sensor();
        return (next_sensor > SENSOR_RIGHT) ? SENSOR_RIGHT : next_sensor;
    endfunction

    // Advance the sequencer by one tick and form the reading it shows
    task automatic advance_tick(input logic [2:0] echo, output urr_result_t r);
        logic [1:0]  s;
        logic        level;
        logic        ended;
        logic [13:0] final_width;
        logic [31:0] product;
        logic        ok;
        logic [1:0]  updated;
        s           = active_sensor();
        level       = echo[s];
        ended       = 1'b0;
        final_width = '0;
        updated     = 2'd0;

        if (slot_elapsed != MAX16)
            slot_elapsed = slot_elapsed + 16'd1;

        case (phase)
            PH_PRE:
            begin
                if (phase_count >= PRE_TRIGGER_TICKS)
                begin
                    phase       = PH_TRIG;
                    phase_count = 5'd1;
                end
                else
                    phase_count = phase_count + 5'd1;
            end
            PH_TRIG:
            begin
                if (phase_count >= trigger_ticks)
                begin
                    phase       = PH_WLOW;
                    phase_count = '0;
                    wait_count  = '0;
                    echo_width  = '0;
                end
                else
                    phase_count = phase_count + 5'd1;
            end
            PH_WLOW, PH_WHIGH, PH_MEAS:
            begin
                if (phase == PH_WLOW)
                begin
                    if (!level)
                        phase = PH_WHIGH;
                end
                else if (phase == PH_WHIGH)
                begin
                    if (level)
                    begin
                        phase      = PH_MEAS;
                        echo_width = 14'd1;
                    end
                end
                else if (level)
                begin
                    if (echo_width != MAX14)
                        echo_width = echo_width + 14'd1;
                end
                else
                begin
                    ended       = 1'b1;
                    final_width = echo_width;
                end
                // a falling edge wins over the timeout on the same tick
                if (!ended)
                begin
                    if (wait_count != MAX14)
                        wait_count = wait_count + 14'd1;
                    if (wait_count >= echo_timeout)
                    begin
                        ended       = 1'b1;
                        final_width = '0;
                    end
                end
                if (ended)
                begin
                    ok             = (final_width >= 14'd1) && (final_width <= max_echo_width);
                    product        = {18'd0, final_width} * {16'd0, scale};
                    distance_mm[s] = ok ? product[29:16] : '0;
                    reading_ok[s]  = ok;
                    next_sensor    = (s >= SENSOR_RIGHT) ? SENSOR_LEFT : s + 2'd1;
                    phase          = PH_IDLE;
                    phase_count    = '0;
                    updated        = s + 2'd1;
                end
            end
            default:
            begin
                phase = PH_IDLE;
                if (slot_elapsed >= slot_ticks)
                begin
                    slot_elapsed = '0;
                    phase        = PH_PRE;
                    phase_count  = 5'd1;
                end
            end
        endcase

        r.trigger_lines  = (phase == PH_TRIG) ? (3'b001 << active_sensor()) : 3'b000;
        r.left_mm        = distance_mm[0];
        r.left_valid     = reading_ok[0];
        r.middle_mm      = distance_mm[1];
        r.middle_valid   = reading_ok[1];
        r.right_mm       = distance_mm[2];
        r.right_valid    = reading_ok[2];
        r.updated_sensor = updated;
        r.busy_res       = (phase != PH_IDLE);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        urr_result_t predicted;
        urr_result_t seen;
        if (!rst_n)
        begin
            slot_ticks     = RST_SLOT_TICKS;
            echo_timeout   = RST_ECHO_TIMEOUT;
            max_echo_width = RST_MAX_ECHO_WIDTH;
            trigger_ticks  = RST_TRIGGER_TICKS;
            scale          = RST_SCALE;
            slot_elapsed   = '0;
            next_sensor    = SENSOR_LEFT;
            phase          = PH_IDLE;
            phase_count    = '0;
            wait_count     = '0;
            echo_width     = '0;
            for (int i = 0; i < 3; i++)
            begin
                distance_mm[i] = '0;
                reading_ok[i]  = 1'b0;
            end
            expected_readings.delete();
            readings_due <= 0;
            mismatches   <= fail_tally;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SLOT_TICKS:     slot_ticks     = cfg_data;
                    REG_ECHO_TIMEOUT:   echo_timeout   = cfg_data[13:0];
                    REG_MAX_ECHO_WIDTH: max_echo_width = cfg_data[13:0];
                    REG_TRIGGER_TICKS:  trigger_ticks  = cfg_data[4:0];
                    REG_SCALE:          scale          = cfg_data;
                    default:            ;
                endcase
            end

            if (s_valid && s_ready)
            begin
                advance_tick(s_data[2:0], predicted);
                expected_readings.push_back(predicted);
            end

            if (m_valid && m_ready)
            begin
                seen = m_data[$bits(urr_result_t)-1:0];
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: result with no reading expected, actual %h", $time, m_data);
                    fail_tally++;
                end
                else
                begin
                    predicted = expected_readings.pop_front();
                    check_field("trigger_lines", predicted.trigger_lines, seen.trigger_lines);
                    check_field("left_mm", predicted.left_mm, seen.left_mm);
                    check_field("left_valid", predicted.left_valid, seen.left_valid);
                    check_field("middle_mm", predicted.middle_mm, seen.middle_mm);
                    check_field("middle_valid", predicted.middle_valid, seen.middle_valid);
                    check_field("right_mm", predicted.right_mm, seen.right_mm);
                    check_field("right_valid", predicted.right_valid, seen.right_valid);
                    check_field("updated_sensor", predicted.updated_sensor,
                                seen.updated_sensor);
                    check_field("busy_res", predicted.busy_res, seen.busy_res);
                end
            end

            readings_due <= expected_readings.size();
            mismatches   <= fail_tally;
        end
    end

endmodule

/* tb/tb_three_channel_ultrasonic_ranger.sv */
`timescale 1ns / 1ps

module tb_three_channel_ultrasonic_ranger;
    import urr_pkg::*;

    localparam int TICKS_PER_PHASE = 62;
    localparam int RANDOM_PHASES   = 8;
    // First index past the register list; writes there must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_FIRST = 3'd5;

    // Directed echo script; the lines differ only on ticks where no echo is
    // sampled, so the sensor in turn does not matter: the first three ticks run
    // under the reset registers, where no ranging can start yet. The rest runs
    // with a slot of 1 tick, timeout 6, width limit 4:
    //   - echo already high when the wait opens, then a width-2 pulse
    //   - width-4 pulse whose falling edge lands on the timeout tick
    //   - echo stuck high, so the wait times out and the reading goes invalid
    localparam int DIRECTED_LEN = 33;
    localparam logic [2:0] DIRECTED_ECHO [DIRECTED_LEN] = '{
        3'd7, 3'd0, 3'd5,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd0, 3'd7, 3'd7, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd7, 3'd7, 3'd0,
        3'd2, 3'd1, 3'd0, 3'd0, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
    };

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_W-1:0]      s_axis_tdata;   // [2:0] echo_lines, upper bits zero
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // from bit 0 up: trigger_lines, left_mm, left_valid, middle_mm, middle_valid,
    // right_mm, right_valid, updated_sensor, busy_res, zero fill
    logic [OUT_DATA_W-1:0]     m_axis_tdata;
    logic                      cfg_we;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [CFG_DATA_W-1:0]     cfg_data;

    int mismatches;
    int readings_due;

    // Traffic shaping knobs, changed per phase
    bit src_gaps;
    bit sink_stalls;
    bit noisy_echo;

    // Echo waveform generator state: each line holds its level for a run of ticks
    logic [2:0] echo_level;
    int         run_left [3];

    three_channel_ultrasonic_ranger u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    ranger_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .s_data       (s_axis_tdata),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_data       (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .readings_due (readings_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run (about 700 ticks, each with the
    // longest sender gap and the longest receiver stall, plus register writes)
    initial
    begin
        #2000000;
        $display("three_channel_ultrasonic_ranger test failed");
        $finish;
    end

    // Receiver: accept freely, with random stall bursts while sink_stalls is set.
    // Exactly one assignment to tready per edge.
    initial
    begin : sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 7);
            end
        end
    end

    // Next echo word: mostly clean pulses of random width per line, sometimes
    // plain per-tick noise to hit glitches and odd edges
    function automatic logic [2:0] next_echo();
        if (noisy_echo)
            return 3'($urandom_range(0, 7));
        for (int b = 0; b < 3; b++)
        begin
            if (run_left[b] == 0)
            begin
                echo_level[b] = ~echo_level[b];
                run_left[b]   = echo_level[b] ? $urandom_range(1, 12) : $urandom_range(1, 20);
            end
            run_left[b]--;
        end
        return echo_level;
    endfunction

    // One tick transfer; hold tvalid high until the block takes it
    task automatic send_tick(input logic [2:0] echo);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - 3){1'b0}}, echo};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_tick(next_echo());
    endtask

    // Drop tvalid and hold until every predicted reading has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (readings_due != 0);
    endtask

    // Write all five registers back to back, then one write past the list
    task automatic program_ranger(input logic [15:0] slot, input logic [13:0] timeout,
                                  input logic [13:0] max_width, input logic [4:0] trig,
                                  input logic [15:0] mm_scale);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_SLOT_TICKS;
        cfg_data <= slot;
        @(posedge clk);
        cfg_addr <= REG_ECHO_TIMEOUT;
        cfg_data <= {2'b00, timeout};
        @(posedge clk);
        cfg_addr <= REG_MAX_ECHO_WIDTH;
        cfg_data <= {2'b00, max_width};
        @(posedge clk);
        cfg_addr <= REG_TRIGGER_TICKS;
        cfg_data <= {11'd0, trig};
        @(posedge clk);
        cfg_addr <= REG_SCALE;
        cfg_data <= mm_scale;
        @(posedge clk);
        cfg_addr <= REG_UNUSED_FIRST + CFG_ADDR_W'($urandom_range(0, 2));
        cfg_data <= 16'($urandom);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Small random settings so rangings finish within a phase; the extremes of
    // some registers come up now and then
    task automatic program_random();
        logic [15:0] slot;
        logic [13:0] timeout;
        logic [13:0] max_width;
        logic [4:0]  trig;
        slot      = 16'($urandom_range(0, 40));
        timeout   = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(0, 16383))
                                                : 14'($urandom_range(1, 50));
        max_width = 14'($urandom_range(0, 25));
        trig      = ($urandom_range(0, 4) == 0) ? 5'd31 : 5'($urandom_range(0, 6));
        program_ranger(slot, timeout, max_width, trig, 16'($urandom_range(0, 65535)));
    endtask

    initial
    begin : stimulus
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_SLOT_TICKS;
        cfg_data      = '0;
        src_gaps      = 1'b1;
        sink_stalls   = 1'b1;
        noisy_echo    = 1'b0;
        echo_level    = 3'b000;
        for (int b = 0; b < 3; b++)
            run_left[b] = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers first, then the scripted echo cases at
        // full scale, so each distance comes out one below the echo width
        for (int i = 0; i < 3; i++)
            send_tick(DIRECTED_ECHO[i]);
        drain();
        program_ranger(16'd1, 14'd6, 14'd4, 5'd1, MAX16);
        for (int i = 3; i < DIRECTED_LEN; i++)
            send_tick(DIRECTED_ECHO[i]);
        drain();

        // All registers at zero: start at once, time out on the first wait tick,
        // no width ever valid
        program_ranger(16'd0, 14'd0, 14'd0, 5'd0, 16'd0);
        send_ticks(TICKS_PER_PHASE);
        drain();

        // All registers at their top values
        program_ranger(MAX16, MAX14, MAX14, 5'd31, MAX16);
        send_ticks(TICKS_PER_PHASE / 2);
        drain();

        // Short slots against long trigger and wait phases give back-to-back
        // rangings; noisy phases can put edges on any tick
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            noisy_echo  = ($urandom_range(0, 4) == 0);
            program_random();
            send_ticks(TICKS_PER_PHASE / 2);
            // in the third phase, pause mid-phase until every reading is out
            if (p == 2)
                drain();
            send_ticks(TICKS_PER_PHASE - TICKS_PER_PHASE / 2);
            drain();
        end

        // Closing stretch at full rate on both sides
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        noisy_echo  = 1'b0;
        program_random();
        send_ticks(TICKS_PER_PHASE);
        drain();
        repeat (4) @(posedge clk);

        if (mismatches == 0 && readings_due == 0)
            $display("three_channel_ultrasonic_ranger test passed");
        else
            $display("three_channel_ultrasonic_ranger test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/urr_pkg.sv
rtl/core/urr_seq.sv
rtl/core/urr_obuf.sv
rtl/core/three_channel_ultrasonic_ranger.sv
rtl/core/urr_checker.sv
tb/ranger_checker.sv
tb/tb_three_channel_ultrasonic_ranger.sv
